@@ rtl/request_ring_admission_core_assert.svh @@
// Assertion macros shared by the request ring admission RTL.
`ifndef REQUEST_RING_ADMISSION_CORE_ASSERT_SVH
`define REQUEST_RING_ADMISSION_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is held.
`define RRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/rra_pkg.sv @@
// Package with constants, codes and types of the request ring admission block.
`default_nettype none

package rra_pkg;

    // Ring geometry and request framing.
    localparam int unsigned RING_DEPTH  = 1024;
    localparam int unsigned FIRST_SLOTS = 1;
    localparam int unsigned CONT_SLOTS  = 5;
    localparam int unsigned MAX_SEGS    = 256;
    localparam int unsigned RING_MARGIN = 2;

    // Field widths.
    localparam int unsigned SEG_W  = 9;
    localparam int unsigned CONS_W = 10;
    localparam int unsigned RET_W  = 11;
    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned FREE_W = $clog2(RING_DEPTH + 1);
    localparam int unsigned NEED_W = 6;
    localparam int unsigned INF_W  = 16;
    localparam int unsigned CFG_W  = 16;

    // Reset value of the in-flight high-water mark.
    localparam logic [INF_W-1:0] HIGH_WATER_RST = INF_W'(1024);

    // Fixed-point reciprocal of the continuation slot count, used for the
    // ceiling division in the entry count.
    localparam int unsigned CEIL_SHIFT = 20;
    localparam int unsigned RECIP_W    = CEIL_SHIFT + 1;
    localparam int unsigned CONT_RECIP = ((1 << CEIL_SHIFT) + CONT_SLOTS - 1) / CONT_SLOTS;
    localparam int unsigned DIVIDEND_W = SEG_W + 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OFFLINE = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_HIWAT   = 2'd3
    } t_status;

    typedef enum logic {
        REQ_SUBMIT = 1'b0,
        REQ_RETIRE = 1'b1
    } t_req_kind;

    typedef enum logic {
        CFG_ONLINE     = 1'b0,
        CFG_HIGH_WATER = 1'b1
    } t_cfg_reg;

    // Configuration write as seen by the admission logic.
    typedef struct packed {
        logic              wr_en;
        t_cfg_reg          index;
        logic [CFG_W-1:0]  wdata;
    } t_cfg_wr;

    // Request held in the input stage, entry count already worked out.
    typedef struct packed {
        t_req_kind         kind;
        logic [NEED_W-1:0] need;
        logic [IDX_W-1:0]  consumer;
        logic              chk;
        logic              trk;
        logic [RET_W-1:0]  retire;
    } t_req;

    // Result of one request.
    typedef struct packed {
        t_status           status;
        logic [NEED_W-1:0] entries_used;
        logic [IDX_W-1:0]  start_index;
        logic [FREE_W-1:0] free_count;
        logic [INF_W-1:0]  inflight_count;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rra_entry_calc.sv @@
// Ring entry count of a request from its data segment count.
`default_nettype none

module rra_entry_calc (
    input  wire logic [rra_pkg::SEG_W-1:0]  i_seg_count,
    output logic      [rra_pkg::NEED_W-1:0] o_need
);

    localparam int unsigned SEG_W      = rra_pkg::SEG_W;
    localparam int unsigned DIVIDEND_W = rra_pkg::DIVIDEND_W;
    localparam int unsigned RECIP_W    = rra_pkg::RECIP_W;
    localparam int unsigned PROD_W     = DIVIDEND_W + RECIP_W;
    localparam int unsigned NEED_W     = rra_pkg::NEED_W;

    logic [SEG_W-1:0]      segs;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PROD_W-1:0]     product;
    logic [NEED_W-1:0]     cont_entries;

    // Clamp oversized requests to the largest segment count.
    always_comb begin
        if (i_seg_count > SEG_W'(rra_pkg::MAX_SEGS)) begin
            segs = SEG_W'(rra_pkg::MAX_SEGS);
        end else begin
            segs = i_seg_count;
        end
    end

    // Ceiling division by the continuation slot count: add the divisor less
    // one, then divide by multiplying with the scaled reciprocal.
    always_comb begin
        dividend = DIVIDEND_W'(segs) - DIVIDEND_W'(rra_pkg::FIRST_SLOTS)
                 + DIVIDEND_W'(rra_pkg::CONT_SLOTS - 1);
        product  = PROD_W'(dividend) * PROD_W'(rra_pkg::CONT_RECIP);
        cont_entries = product[rra_pkg::CEIL_SHIFT +: NEED_W];
    end

    // One entry carries the first slots; continuation entries hold the rest.
    always_comb begin
        if (segs <= SEG_W'(rra_pkg::FIRST_SLOTS)) begin
            o_need = NEED_W'(1);
        end else begin
            o_need = NEED_W'(1) + cont_entries;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rra_admit.sv @@
// Ring state, configuration registers and the admission decision.
`default_nettype none
`include "request_ring_admission_core_assert.svh"

module rra_admit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rra_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_fire,
    input  wire rra_pkg::t_req    i_req,
    output rra_pkg::t_result      o_res
);

    localparam int unsigned IDX_W  = rra_pkg::IDX_W;
    localparam int unsigned FREE_W = rra_pkg::FREE_W;
    localparam int unsigned INF_W  = rra_pkg::INF_W;
    localparam logic [INF_W-1:0] INF_MAX = {INF_W{1'b1}};

    logic              r_online;
    logic [INF_W-1:0]  r_high_water;
    logic [IDX_W-1:0]  r_write_index;
    logic [FREE_W-1:0] r_cached_free;
    logic [INF_W-1:0]  r_inflight;

    logic [IDX_W-1:0]  n_write_index;
    logic [FREE_W-1:0] n_cached_free;
    logic [INF_W-1:0]  n_inflight;

    logic [FREE_W-1:0] need_ext;
    logic [FREE_W-1:0] need_mrg;
    logic [FREE_W-1:0] refresh_free;
    logic [FREE_W-1:0] free_now;
    logic [IDX_W:0]    wr_sum;
    logic [IDX_W-1:0]  wr_next;
    logic [INF_W:0]    inf_sum;
    logic [INF_W-1:0]  inf_charged;
    logic [INF_W-1:0]  ret_ext;
    logic              refresh;
    logic              fits;
    logic              over_hw;

    // Space test, with the free count refreshed from the consumer index
    // when the cached value is too low.
    always_comb begin
        need_ext = FREE_W'(i_req.need);
        need_mrg = need_ext + FREE_W'(rra_pkg::RING_MARGIN);
        refresh  = (need_mrg >= r_cached_free);
        if (r_write_index < i_req.consumer) begin
            refresh_free = FREE_W'(i_req.consumer - r_write_index);
        end else begin
            refresh_free = FREE_W'(rra_pkg::RING_DEPTH)
                         - FREE_W'(r_write_index - i_req.consumer);
        end
        free_now = refresh ? refresh_free : r_cached_free;
        fits     = (need_mrg < free_now);
    end

    // High-water test and the saturating in-flight charge.
    always_comb begin
        inf_sum = {1'b0, r_inflight} + (INF_W + 1)'(i_req.need);
        over_hw = i_req.chk && (inf_sum >= {1'b0, r_high_water});
        if (inf_sum > {1'b0, INF_MAX}) begin
            inf_charged = INF_MAX;
        end else begin
            inf_charged = inf_sum[INF_W-1:0];
        end
        ret_ext = INF_W'(i_req.retire);
    end

    // Write index advanced around the ring.
    always_comb begin
        wr_sum = {1'b0, r_write_index} + (IDX_W + 1)'(i_req.need);
        if (wr_sum >= (IDX_W + 1)'(rra_pkg::RING_DEPTH)) begin
            wr_next = IDX_W'(wr_sum - (IDX_W + 1)'(rra_pkg::RING_DEPTH));
        end else begin
            wr_next = wr_sum[IDX_W-1:0];
        end
    end

    // Decision: retire, offline, no space, high water, then accept.
    always_comb begin
        n_write_index      = r_write_index;
        n_cached_free      = r_cached_free;
        n_inflight         = r_inflight;
        o_res.status       = rra_pkg::ST_OK;
        o_res.entries_used = '0;
        o_res.start_index  = r_write_index;
        priority if (i_req.kind == rra_pkg::REQ_RETIRE) begin
            n_inflight = (ret_ext >= r_inflight) ? '0 : r_inflight - ret_ext;
        end else if (!r_online) begin
            o_res.status = rra_pkg::ST_OFFLINE;
        end else if (!fits) begin
            n_cached_free = free_now;
            o_res.status  = rra_pkg::ST_NOSPACE;
        end else if (over_hw) begin
            n_cached_free = free_now;
            o_res.status  = rra_pkg::ST_HIWAT;
        end else begin
            n_write_index      = wr_next;
            n_cached_free      = free_now - need_ext;
            n_inflight         = i_req.trk ? inf_charged : r_inflight;
            o_res.entries_used = i_req.need;
        end
        o_res.free_count     = n_cached_free;
        o_res.inflight_count = n_inflight;
    end

    // Configuration registers and ring state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online      <= 1'b0;
            r_high_water  <= rra_pkg::HIGH_WATER_RST;
            r_write_index <= '0;
            r_cached_free <= FREE_W'(rra_pkg::RING_DEPTH);
            r_inflight    <= '0;
        end else begin
            if (i_cfg.wr_en) begin
                unique case (i_cfg.index)
                    rra_pkg::CFG_ONLINE: begin
                        r_online <= i_cfg.wdata[0];
                    end
                    rra_pkg::CFG_HIGH_WATER: begin
                        r_high_water <= INF_W'(i_cfg.wdata);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_write_index <= n_write_index;
                r_cached_free <= n_cached_free;
                r_inflight    <= n_inflight;
            end
        end
    end

    // The cached free count never exceeds the ring depth.
    `RRA_ASSERT(a_free_bound, i_clk, i_rst_n, r_cached_free <= FREE_W'(rra_pkg::RING_DEPTH), "cached free count above ring depth")
    // The write index moves only on a transfer out of the input stage.
    `RRA_ASSERT(a_idx_hold, i_clk, i_rst_n, !i_fire |=> $stable(r_write_index), "write index moved without a request")
    // A refused request takes no entries and reports the current write index.
    `RRA_ASSERT(a_refuse_empty, i_clk, i_rst_n, i_fire && (o_res.status != rra_pkg::ST_OK) |-> (o_res.entries_used == '0) && (o_res.start_index == r_write_index), "refused request took ring entries")

endmodule

`default_nettype wire

@@ rtl/request_ring_admission_core.sv @@
// Top level of the request ring admission block: input stage and result register.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------------
//  request  | i_in_valid / o_in_ready   | req_type, seg_count, consumer_index,
//           |                           | check_high_water, track_inflight,
//           |                           | retire_count
//  result   | o_out_valid / i_out_ready | status, entries_used, start_index,
//           |                           | free_count, inflight_count
//  config   | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
// One request per cycle is sustained while the result channel does not stall. A request
// waits in the input stage, where its entry count is already held, and its result is
// then captured in the result register; the ring state update sits in that same step.
// Reset is synchronous and active low; it takes effect with no sweep.
// A stalled result holds the input stage, which in turn drops o_in_ready.
`default_nettype none
`include "request_ring_admission_core_assert.svh"

module request_ring_admission_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration writes.
    input  wire logic                           i_cfg_wr_en,
    input  wire logic                           i_cfg_index,
    input  wire logic [rra_pkg::CFG_W-1:0]      i_cfg_wdata,
    // Request channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_req_type,
    input  wire logic [rra_pkg::SEG_W-1:0]      i_seg_count,
    input  wire logic [rra_pkg::CONS_W-1:0]     i_consumer_index,
    input  wire logic                           i_check_high_water,
    input  wire logic                           i_track_inflight,
    input  wire logic [rra_pkg::RET_W-1:0]      i_retire_count,
    // Result channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_status,
    output logic [rra_pkg::NEED_W-1:0]          o_entries_used,
    output logic [rra_pkg::IDX_W-1:0]           o_start_index,
    output logic [rra_pkg::FREE_W-1:0]          o_free_count,
    output logic [rra_pkg::INF_W-1:0]           o_inflight_count
);

    logic              r_in_valid;
    rra_pkg::t_req     r_req;
    logic              r_out_valid;
    rra_pkg::t_result  r_res;

    rra_pkg::t_req     n_req;
    rra_pkg::t_result  res;
    rra_pkg::t_cfg_wr  cfg;
    logic [rra_pkg::NEED_W-1:0] need;
    logic              in_xfer;
    logic              stage_adv;

    // Entry count is worked out before the input stage.
    rra_entry_calc u_entry_calc (
        .i_seg_count (i_seg_count),
        .o_need      (need)
    );

    always_comb begin
        n_req.kind     = rra_pkg::t_req_kind'(i_req_type);
        n_req.need     = need;
        n_req.consumer = rra_pkg::IDX_W'(i_consumer_index);
        n_req.chk      = i_check_high_water;
        n_req.trk      = i_track_inflight;
        n_req.retire   = i_retire_count;
    end

    always_comb begin
        cfg.wr_en = i_cfg_wr_en;
        cfg.index = rra_pkg::t_cfg_reg'(i_cfg_index);
        cfg.wdata = i_cfg_wdata;
    end

    // The input stage moves on whenever the result register is free or drains.
    assign stage_adv  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    rra_admit u_admit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (stage_adv),
        .i_req   (r_req),
        .o_res   (res)
    );

    // Input stage and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (stage_adv) begin
                r_in_valid <= 1'b0;
            end
            if (stage_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= n_req;
        end
        if (stage_adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_res.status;
    assign o_entries_used   = r_res.entries_used;
    assign o_start_index    = r_res.start_index;
    assign o_free_count     = r_res.free_count;
    assign o_inflight_count = r_res.inflight_count;

    // A request waiting in the input stage is never dropped.
    `RRA_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_valid && !stage_adv |=> r_in_valid, "request lost from input stage")

endmodule

`default_nettype wire
